[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the block.
// No dependencies; clk and rst_n must exist where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define LBP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition in one cycle implies a property in the next
`define LBP_ASSERT_HOLD(lbl, cond, held, msg) \
    `LBP_ASSERT(lbl, (cond) |=> (held), msg)

`endif

[hw/rtl/lbp_pkg.sv]
// Types and constants for the 3x3 LBP code stream.
// No dependencies; used by every module of the block but lbp_ram.
`timescale 1ns / 1ps

package lbp_pkg;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 10;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_FRAME_HEIGHT = 4096;
    localparam int WIN_N      = 9;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic ACTION_PIXEL = 1'b0;
    localparam logic ACTION_FLUSH = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(480);

    // window slot of neighbour n; window is row-major, top row first
    localparam logic [3:0] NB_IDX [8] = '{4'd3, 4'd6, 4'd7, 4'd8, 4'd5, 4'd2, 4'd1, 4'd0};
    localparam logic [3:0] CENTER_IDX = 4'd4;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] pixel_value;
    } src_item_t;

    typedef struct packed {
        logic [7:0]           pattern_code;
        logic [ROW_OUT_W-1:0] pixel_row;
        logic [COL_OUT_W-1:0] pixel_col;
        logic                 last_of_frame;
    } code_item_t;

    // window control from the pipeline to the window unit
    typedef struct packed {
        logic shift;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } win_ctl_t;

endpackage

[hw/rtl/lbp_ram.sv]
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/lbp_window.sv]
// 3x3 pixel window and the eight neighbour comparisons.
// Depends on lbp_pkg.
`timescale 1ns / 1ps

module lbp_window (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lbp_pkg::win_ctl_t        ctl,
    input  logic [lbp_pkg::PIX_W-1:0] top_px,
    input  logic [lbp_pkg::PIX_W-1:0] mid_px,
    input  logic [lbp_pkg::PIX_W-1:0] new_px,
    output logic [7:0]               code
);

    import lbp_pkg::*;

    logic [PIX_W-1:0] win_reg  [WIN_N];
    logic [PIX_W-1:0] win_next [WIN_N];
    logic [PIX_W-1:0] shifted  [WIN_N];
    logic [7:0]       nb_ok;

    always_comb
    begin
        shifted[0] = win_reg[1];
        shifted[1] = win_reg[2];
        shifted[2] = top_px;
        shifted[3] = win_reg[4];
        shifted[4] = win_reg[5];
        shifted[5] = mid_px;
        shifted[6] = win_reg[7];
        shifted[7] = win_reg[8];
        shifted[8] = new_px;
        for (int i = 0; i < WIN_N; i++)
        begin
            win_next[i] = ctl.shift ? shifted[i] : win_reg[i];
        end
    end

    // frame-edge masks per neighbour
    always_comb
    begin
        nb_ok[0] = ctl.left_ok;
        nb_ok[1] = ctl.bot_ok & ctl.left_ok;
        nb_ok[2] = ctl.bot_ok;
        nb_ok[3] = ctl.bot_ok & ctl.right_ok;
        nb_ok[4] = ctl.right_ok;
        nb_ok[5] = ctl.top_ok & ctl.right_ok;
        nb_ok[6] = ctl.top_ok;
        nb_ok[7] = ctl.top_ok & ctl.left_ok;
        for (int n = 0; n < 8; n++)
        begin
            code[n] = nb_ok[n] && (shifted[CENTER_IDX] < shifted[NB_IDX[n]]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN_N; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            win_reg <= win_next;
        end
    end

endmodule

[hw/rtl/lbp_3x3_code_stream.sv]
// 3x3 local binary pattern code stream: line stores, window, result register.
// Depends on lbp_pkg, lbp_ram and lbp_window.
// Path: an accepted item is registered in the read/write stage, then its code in the result
//   register; the code for raster position p comes with the item at position p+width+1.
// Throughput: one item per cycle while code_stall is low; both line stores are read and written once per item.
// Reset: counters zero, frame 640x480, window zero; line stores are not cleared.
`timescale 1ns / 1ps

module lbp_3x3_code_stream #(
    parameter int MAX_LINE_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            src_valid,
    output logic                            src_stall,
    input  lbp_pkg::src_item_t              src_item,
    output logic                            code_valid,
    input  logic                            code_stall,
    output lbp_pkg::code_item_t             code_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import lbp_pkg::*;

    localparam int AW = $clog2(MAX_LINE_WIDTH);
    localparam int WW = $clog2(MAX_LINE_WIDTH + 1);

    // configuration
    logic [FW_W-1:0] frame_width_reg, frame_width_next;
    logic [FH_W-1:0] frame_height_reg, frame_height_next;
    logic            cfg_fire;
    logic            cfg_restart;
    logic [WW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;

    // raster position of the next item
    logic [AW-1:0]   col_reg, col_next;
    logic [FH_W-1:0] row_reg, row_next;

    // accept-side decode
    logic            src_fire;
    logic            trailing;
    logic            take;
    logic [PIX_W-1:0] px_in;
    logic [FH_W:0]   cr;
    logic [FH_W-1:0] cr_u;
    logic [AW-1:0]   cc;
    logic [AW-1:0]   w_last;
    logic            emit;
    logic            last;
    logic [AW:0]     col_inc;

    // read/write stage
    logic            s1_valid_reg, s1_valid_next;
    logic            s1_fwd_reg, s1_fwd_next;
    logic [AW-1:0]   s1_addr_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic            s1_emit_reg;
    logic            s1_last_reg;
    logic [ROW_OUT_W-1:0] s1_row_reg;
    logic [COL_OUT_W-1:0] s1_col_reg;
    logic            s1_top_ok_reg, s1_bot_ok_reg, s1_left_ok_reg, s1_right_ok_reg;
    logic [PIX_W-1:0] fwd_top_reg, fwd_mid_reg;
    logic            s1_adv;
    logic [PIX_W-1:0] up_q, mid_q, top_v, mid_v;
    win_ctl_t        win_ctl;
    logic [7:0]      code_w;

    // result register
    logic            code_valid_reg, code_valid_next;
    code_item_t      code_item_reg;
    logic            out_free;

    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid & cfg_ready;
    assign cfg_restart = cfg_fire &&
                         (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = cfg_data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size, saturated
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(frame_width_reg) > MAX_LINE_WIDTH)
        begin
            eff_w = WW'(MAX_LINE_WIDTH);
        end
        else
        begin
            eff_w = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0)
        begin
            eff_h = FH_W'(1);
        end
        else if (32'(frame_height_reg) > MAX_FRAME_HEIGHT)
        begin
            eff_h = FH_W'(MAX_FRAME_HEIGHT);
        end
        else
        begin
            eff_h = frame_height_reg;
        end
    end

    assign out_free  = !code_valid_reg || !code_stall;
    assign s1_adv    = s1_valid_reg && out_free;
    assign src_stall = s1_valid_reg && !out_free;
    assign src_fire  = src_valid && !src_stall;

    // centre of the window trails the input by one row and one column
    assign trailing = row_reg >= eff_h;
    assign take     = src_fire && !(src_item.action == ACTION_FLUSH && !trailing);
    assign px_in    = trailing ? '0 : src_item.pixel_value;
    assign w_last   = AW'(eff_w - WW'(1));
    assign cr       = {1'b0, row_reg} - ((col_reg == '0) ? (FH_W+1)'(2) : (FH_W+1)'(1));
    assign cr_u     = cr[FH_W-1:0];
    assign cc       = (col_reg == '0) ? w_last : col_reg - AW'(1);
    assign emit     = !cr[FH_W] && (cr_u < eff_h);
    assign last     = emit && (cr_u == eff_h - FH_W'(1)) && (cc == w_last);
    assign col_inc  = {1'b0, col_reg} + (AW+1)'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (take)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= (AW+1)'(eff_w))
            begin
                col_next = '0;
                row_next = row_reg + FH_W'(1);
            end
            else
            begin
                col_next = col_inc[AW-1:0];
            end
        end
        else
        begin
            col_next = col_reg;
            row_next = row_reg;
        end
    end

    // same-entry write in the cycle of the read: RAM returns old data, use the write
    assign s1_fwd_next   = take ? (s1_adv && (s1_addr_reg == col_reg)) : s1_fwd_reg;
    assign s1_valid_next = take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    lbp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_upper_ram (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (col_reg),
        .rd_data (up_q),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (mid_v)
    );

    lbp_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LINE_WIDTH)
    ) u_middle_ram (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (col_reg),
        .rd_data (mid_q),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_px_reg)
    );

    assign top_v = s1_fwd_reg ? fwd_top_reg : up_q;
    assign mid_v = s1_fwd_reg ? fwd_mid_reg : mid_q;

    always_comb
    begin
        win_ctl.shift    = s1_adv;
        win_ctl.top_ok   = s1_top_ok_reg;
        win_ctl.bot_ok   = s1_bot_ok_reg;
        win_ctl.left_ok  = s1_left_ok_reg;
        win_ctl.right_ok = s1_right_ok_reg;
    end

    lbp_window u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (win_ctl),
        .top_px (top_v),
        .mid_px (mid_v),
        .new_px (s1_px_reg),
        .code   (code_w)
    );

    always_comb
    begin
        code_valid_next = code_valid_reg;
        if (s1_adv && s1_emit_reg)
        begin
            code_valid_next = 1'b1;
        end
        else if (!code_stall)
        begin
            code_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            s1_fwd_reg       <= 1'b0;
            code_valid_reg   <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            s1_valid_reg     <= s1_valid_next;
            s1_fwd_reg       <= s1_fwd_next;
            code_valid_reg   <= code_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_addr_reg     <= col_reg;
            s1_px_reg       <= px_in;
            s1_emit_reg     <= emit;
            s1_last_reg     <= last;
            s1_row_reg      <= cr_u[ROW_OUT_W-1:0];
            s1_col_reg      <= COL_OUT_W'(cc);
            s1_top_ok_reg   <= cr_u != '0;
            s1_bot_ok_reg   <= cr_u != eff_h - FH_W'(1);
            s1_left_ok_reg  <= cc != '0;
            s1_right_ok_reg <= cc != w_last;
            fwd_top_reg     <= mid_v;
            fwd_mid_reg     <= s1_px_reg;
        end
        if (s1_adv && s1_emit_reg)
        begin
            code_item_reg.pattern_code  <= code_w;
            code_item_reg.pixel_row     <= s1_row_reg;
            code_item_reg.pixel_col     <= s1_col_reg;
            code_item_reg.last_of_frame <= s1_last_reg;
        end
    end

    assign code_valid = code_valid_reg;
    assign code_item  = code_item_reg;

endmodule

[hw/rtl/lbp_checker.sv]
// Port-level checks for lbp_3x3_code_stream, bound to the top level.
// Depends on lbp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                src_valid,
    input logic                src_stall,
    input logic                code_valid,
    input logic                code_stall,
    input lbp_pkg::code_item_t code_item
);

    `LBP_ASSERT_HOLD(a_code_valid_held, code_valid && code_stall, code_valid, "result beat dropped under stall")
    `LBP_ASSERT_HOLD(a_code_item_held, code_valid && code_stall, $stable(code_item), "stalled result beat changed")
    // input side only waits on a full, stalled result register
    `LBP_ASSERT(a_src_stall_cause, src_stall |-> (code_valid && code_stall), "input stalled without output backpressure")
    // a new result follows an accepted beat through the read/write stage and the result register
    `LBP_ASSERT(a_code_from_beat, $rose(code_valid) |-> $past(src_valid && !src_stall, 2), "result without an accepted beat")

endmodule

bind lbp_3x3_code_stream lbp_checker u_lbp_checker (.*);

[sim/lbp_3x3_code_stream_tb.sv]
// Self-checking bench for lbp_3x3_code_stream: directed plan, extreme frames, random frames.
// Depends on lbp_pkg and the lbp_3x3_code_stream RTL; codes are checked against an
// in-bench window/line-store predictor.
`timescale 1ns / 1ps

module lbp_3x3_code_stream_tb;

    import lbp_pkg::*;

    localparam int LINE_DEPTH    = 1024;
    localparam int RANDOM_BEATS  = 260;
    localparam int WIDE_TAIL     = 16;
    localparam int TALL_ROWS     = 40;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int IDLE_PCT      = 14;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(15);
    localparam src_item_t  FLUSH_BEAT = '{action: ACTION_FLUSH, pixel_value: 8'd0};
    localparam code_item_t NO_CODE    = '0;

    // neighbour offsets for code bits 0..7
    localparam int NB_DROW [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    localparam int NB_DCOL [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};

    typedef enum logic { STEP_BEAT, STEP_WRITE } step_kind_t;

    typedef struct {
        step_kind_t               kind;
        logic [CFG_IDX_W-1:0]     index;
        logic [CFG_DATA_W-1:0]    value;
        src_item_t                item;
        bit                       typed;
        code_item_t               code;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   src_valid = 1'b0;
    logic                   src_stall;
    src_item_t              src_item = '0;
    logic                   code_valid;
    logic                   code_stall = 1'b0;
    code_item_t             code_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [FW_W-1:0]  geom_width  = FRAME_WIDTH_RESET;
    logic [FH_W-1:0]  geom_height = FRAME_HEIGHT_RESET;
    logic [7:0]       line_above [LINE_DEPTH] = '{default: 8'd0};
    logic [7:0]       line_prev  [LINE_DEPTH] = '{default: 8'd0};
    logic [7:0]       win_px     [9] = '{default: 8'd0};
    int               at_row = 0;
    int               at_col = 0;

    code_item_t       pending_codes [$];
    plan_row_t        directed_plan [$];

    int               error_count   = 0;
    int               stepped_beats = 0;
    int               codes_checked = 0;
    int               frames_seen   = 0;
    int               reg_writes    = 0;
    int               cycle_count   = 0;
    bit               steady        = 1'b0;

    lbp_3x3_code_stream dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_item   (src_item),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_item  (code_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic int used_width();
        int v = int'(geom_width);
        if (v < 1)
            v = 1;
        if (v > LINE_DEPTH)
            v = LINE_DEPTH;
        return v;
    endfunction

    function automatic int used_height();
        int v = int'(geom_height);
        if (v < 1)
            v = 1;
        if (v > MAX_FRAME_HEIGHT)
            v = MAX_FRAME_HEIGHT;
        return v;
    endfunction

    function automatic src_item_t pixel_beat(input logic [7:0] v);
        return '{action: ACTION_PIXEL, pixel_value: v};
    endfunction

    function automatic logic [7:0] pick_pixel(input int style);
        case (style)
            0:       return 8'($urandom_range(0, 255));
            1:       return 8'(120 + $urandom_range(0, 3));
            default: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // Advances the window model by one accepted beat; has_code tells whether a
    // code leaves the window on this beat.
    task automatic lbp_predict(input src_item_t it, output bit has_code,
                               output code_item_t code);
        int         w, h, r, c, cr, cc, nr, nc;
        bit         trailing;
        logic [7:0] px, top, mid;
        logic [7:0] bits;
        has_code = 1'b0;
        code = NO_CODE;
        w = used_width();
        h = used_height();
        r = at_row;
        c = at_col;
        trailing = (r >= h);
        // flush before the frame is complete is dropped
        if (it.action == ACTION_FLUSH && !trailing)
            return;
        stepped_beats++;
        px = trailing ? 8'd0 : it.pixel_value;
        top = line_above[c];
        mid = line_prev[c];
        line_above[c] = mid;
        line_prev[c] = px;
        for (int k = 0; k < 3; k++)
        begin
            win_px[k*3]   = win_px[k*3+1];
            win_px[k*3+1] = win_px[k*3+2];
        end
        win_px[2] = top;
        win_px[5] = mid;
        win_px[8] = px;
        if (c >= 1)
        begin
            cr = r - 1;
            cc = c - 1;
        end
        else
        begin
            cr = r - 2;
            cc = w - 1;
        end
        if (cr >= 0 && cr < h)
        begin
            bits = 8'd0;
            for (int n = 0; n < 8; n++)
            begin
                nr = cr + NB_DROW[n];
                nc = cc + NB_DCOL[n];
                if (nr >= 0 && nr < h && nc >= 0 && nc < w
                    && win_px[4] < win_px[(1 + NB_DROW[n]) * 3 + 1 + NB_DCOL[n]])
                    bits[n] = 1'b1;
            end
            has_code = 1'b1;
            code.pattern_code  = bits;
            code.pixel_row     = ROW_OUT_W'(cr);
            code.pixel_col     = COL_OUT_W'(cc);
            code.last_of_frame = (cr == h - 1) && (cc == w - 1);
            if (code.last_of_frame)
            begin
                at_row = 0;
                at_col = 0;
                return;
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        at_row = r & 'h1FFF;
        at_col = c;
    endtask

    // One source beat; a typed code overrides the predicted one.
    task automatic send_beat(input src_item_t it, input bit typed = 1'b0,
                             input code_item_t typed_code = '0);
        bit         has_code;
        code_item_t code;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= it;
        do
            @(posedge clk);
        while (src_stall);
        lbp_predict(it, has_code, code);
        if (typed)
            pending_codes = {pending_codes, typed_code};
        else if (has_code)
            pending_codes = {pending_codes, code};
    endtask

    // Wait until every pending code is out and the pipeline has run dry.
    task automatic settle();
        src_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        reg_writes++;
        case (idx)
            REG_FRAME_WIDTH:
            begin
                geom_width = val[FW_W-1:0];
                at_row = 0;
                at_col = 0;
            end
            REG_FRAME_HEIGHT:
            begin
                geom_height = val[FH_W-1:0];
                at_row = 0;
                at_col = 0;
            end
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] wdata,
                                input logic [CFG_DATA_W-1:0] hdata);
        settle();
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_FRAME_WIDTH, wdata);
            write_reg(REG_FRAME_HEIGHT, hdata);
        end
        else
        begin
            write_reg(REG_FRAME_HEIGHT, hdata);
            write_reg(REG_FRAME_WIDTH, wdata);
        end
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Full frame plus trailing flushes; a broken frame stops partway with no trailing flush.
    task automatic stream_frame(input int fw, input int fh, input bit may_break,
                                output bit broken);
        int npx;
        int style;
        style = $urandom_range(0, 2);
        broken = may_break && ($urandom_range(0, 9) == 0);
        npx = broken ? $urandom_range(0, fw * fh - 1) : fw * fh;
        for (int i = 0; i < npx; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                send_beat(FLUSH_BEAT);
            send_beat(pixel_beat(pick_pixel(style)));
        end
        if (!broken)
        begin
            // a pixel beat past the frame end counts as a flush
            for (int i = 0; i <= fw; i++)
                send_beat($urandom_range(0, 4) == 0 ? pixel_beat(pick_pixel(0)) : FLUSH_BEAT);
        end
    endtask

    task automatic check_code(input code_item_t got);
        code_item_t want;
        if (pending_codes.size() == 0)
        begin
            $error("code beat with nothing pending: row %0d col %0d code %h",
                   got.pixel_row, got.pixel_col, got.pattern_code);
            error_count++;
            return;
        end
        want = pending_codes.pop_front();
        codes_checked++;
        if (got.last_of_frame === 1'b1)
            frames_seen++;
        if (got.pattern_code !== want.pattern_code)
        begin
            $error("pattern_code: expected %h, actual %h", want.pattern_code, got.pattern_code);
            error_count++;
        end
        if (got.pixel_row !== want.pixel_row)
        begin
            $error("pixel_row: expected %0d, actual %0d", want.pixel_row, got.pixel_row);
            error_count++;
        end
        if (got.pixel_col !== want.pixel_col)
        begin
            $error("pixel_col: expected %0d, actual %0d", want.pixel_col, got.pixel_col);
            error_count++;
        end
        if (got.last_of_frame !== want.last_of_frame)
        begin
            $error("last_of_frame: expected %b, actual %b",
                   want.last_of_frame, got.last_of_frame);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && code_valid && !code_stall)
            check_code(code_item);
        code_stall <= rst_n && !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d codes still pending",
                     cycle_count, pending_codes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int                     base;
        int                     fw;
        int                     fh;
        int                     nframes;
        bit                     broken;
        logic [CFG_DATA_W-1:0]  wdata;
        logic [CFG_DATA_W-1:0]  hdata;

        // 3x3 frame: a dark centre in a bright ring gives FF there and 0 elsewhere
        directed_plan = '{
            '{STEP_BEAT,  '0, '0, FLUSH_BEAT, 1'b0, NO_CODE},
            '{STEP_WRITE, REG_FRAME_WIDTH,  16'hF803, '0, 1'b0, NO_CODE},
            '{STEP_WRITE, REG_FRAME_HEIGHT, 16'hE003, '0, 1'b0, NO_CODE},
            '{STEP_WRITE, REG_UNMAPPED,     16'hFFFF, '0, 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'hFF), 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'hFF), 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'hFF), 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, FLUSH_BEAT, 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'hFF), 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'h00), 1'b1, '{8'h00, 12'd0, 10'd0, 1'b0}},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'hFF), 1'b1, '{8'h00, 12'd0, 10'd1, 1'b0}},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'hFF), 1'b1, '{8'h00, 12'd0, 10'd2, 1'b0}},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'hFF), 1'b1, '{8'h00, 12'd1, 10'd0, 1'b0}},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'hFF), 1'b1, '{8'hFF, 12'd1, 10'd1, 1'b0}},
            '{STEP_BEAT,  '0, '0, FLUSH_BEAT,        1'b1, '{8'h00, 12'd1, 10'd2, 1'b0}},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'h5A), 1'b1, '{8'h00, 12'd2, 10'd0, 1'b0}},
            '{STEP_BEAT,  '0, '0, FLUSH_BEAT,        1'b1, '{8'h00, 12'd2, 10'd1, 1'b0}},
            '{STEP_BEAT,  '0, '0, FLUSH_BEAT,        1'b1, '{8'h00, 12'd2, 10'd2, 1'b1}},
            // zero in both registers saturates to a one-pixel frame
            '{STEP_WRITE, REG_FRAME_WIDTH,  16'h0000, '0, 1'b0, NO_CODE},
            '{STEP_WRITE, REG_FRAME_HEIGHT, 16'h0000, '0, 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'hA5), 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, FLUSH_BEAT,        1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, FLUSH_BEAT,        1'b1, '{8'h00, 12'd0, 10'd0, 1'b1}},
            '{STEP_WRITE, REG_FRAME_WIDTH,  16'h0002, '0, 1'b0, NO_CODE},
            '{STEP_WRITE, REG_FRAME_HEIGHT, 16'h0002, '0, 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'h80), 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'h7F), 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'h01), 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, pixel_beat(8'hFE), 1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, FLUSH_BEAT,        1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, FLUSH_BEAT,        1'b0, NO_CODE},
            '{STEP_BEAT,  '0, '0, FLUSH_BEAT,        1'b0, NO_CODE}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == STEP_WRITE)
            begin
                settle();
                write_reg(directed_plan[i].index, directed_plan[i].value);
                cfg_valid <= 1'b0;
            end
            else
                send_beat(directed_plan[i].item, directed_plan[i].typed,
                          directed_plan[i].code);
        end

        // widest line, stall-free: one full row, then a few trailing codes
        steady = 1'b1;
        set_geometry(16'h07FF, 16'h0001);
        for (int i = 0; i < LINE_DEPTH; i++)
            send_beat(pixel_beat(pick_pixel(0)));
        for (int i = 0; i < WIDE_TAIL; i++)
            send_beat(FLUSH_BEAT);
        settle();
        steady = 1'b0;

        // one column under the tallest height, cut short
        set_geometry(16'hF801, 16'h1FFF);
        for (int i = 0; i < TALL_ROWS; i++)
            send_beat(pixel_beat(pick_pixel(2)));

        base = stepped_beats;
        while (stepped_beats - base < RANDOM_BEATS)
        begin
            fw = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 96) : $urandom_range(1, 12);
            fh = (fw > 12) ? $urandom_range(1, 3) : $urandom_range(1, 8);
            wdata = {5'($urandom), 11'(fw)};
            hdata = {3'($urandom), 13'(fh)};
            if (fw == 1 && $urandom_range(0, 1))
                wdata[FW_W-1:0] = '0;
            if (fh == 1 && $urandom_range(0, 1))
                hdata[FH_W-1:0] = '0;
            set_geometry(wdata, hdata);
            nframes = $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++)
            begin
                stream_frame(fw, fh, 1'b1, broken);
                if (broken)
                    break;
            end
        end

        settle();
        $display("Ran %0d stepping beats through %0d register writes; checked %0d codes",
                 stepped_beats, reg_writes, codes_checked);
        $display("with %0d frames completed; line widths from 1 up to the saturated 1024",
                 frames_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_ram.sv
hw/rtl/lbp_window.sv
hw/rtl/lbp_3x3_code_stream.sv
hw/rtl/lbp_checker.sv
sim/lbp_3x3_code_stream_tb.sv
